// File: hdl/rgb_status_led_patterner_defines.svh
// assertion macros shared by the rgb status led patterner checker
// no dependencies; include by bare file name
`ifndef RGB_STATUS_LED_PATTERNER_DEFINES_SVH
`define RGB_STATUS_LED_PATTERNER_DEFINES_SVH

// same-cycle implication, quiet during reset
`define RSL_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rsl assertion failed");

// next-cycle implication, quiet during reset
`define RSL_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rsl assertion failed");

`endif

// File: hdl/rsl_pkg.sv
// shared types and constants for the rgb status led patterner
// no dependencies
`default_nettype none

package rsl_pkg;

  localparam int TIME_WIDTH = 32;
  typedef logic [TIME_WIDTH-1:0] time_t;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_TUNNEL   = 2'd1,
    CMD_IDENTIFY = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_OFF       = 2'd0,
    MODE_HEARTBEAT = 2'd1,
    MODE_STATUS    = 2'd2,
    MODE_FULL      = 2'd3
  } mode_t;

  localparam logic [2:0] ST_NO_NET   = 3'd0;
  localparam logic [2:0] ST_UNCONF   = 3'd1;
  localparam logic [2:0] ST_ENROLL   = 3'd2;
  localparam logic [2:0] ST_RUNNING  = 3'd3;
  localparam logic [2:0] ST_ERROR    = 3'd4;

  // bit0 red, bit1 green, bit2 blue
  localparam logic [2:0] LVL_R = 3'b001;
  localparam logic [2:0] LVL_G = 3'b010;
  localparam logic [2:0] LVL_B = 3'b100;

  localparam time_t UPDATE_MS = time_t'(50);
  localparam time_t FLASH_MS  = time_t'(250);

  // blink periods, one per phase residue of the counter
  localparam logic [8:0]  PER_300  = 9'd300;
  localparam logic [9:0]  PER_1000 = 10'd1000;
  localparam logic [10:0] PER_2000 = 11'd2000;
  localparam logic [8:0]  PER_400  = 9'd400;
  localparam logic [12:0] PER_5000 = 13'd5000;

  localparam logic [8:0]  IDENT_STEP  = 9'd100;
  localparam logic [8:0]  IDENT_STEP2 = 9'd200;
  localparam logic [8:0]  DUTY_300    = 9'd150;
  localparam logic [9:0]  DUTY_1000   = 10'd500;
  localparam logic [10:0] DUTY_2000   = 11'd1000;
  localparam logic [8:0]  DUTY_400    = 9'd200;
  localparam logic [12:0] DUTY_5000   = 13'd120;

  typedef struct packed {
    logic [8:0]  p300;
    logic [9:0]  p1000;
    logic [10:0] p2000;
    logic [8:0]  p400;
    logic [12:0] p5000;
  } phase_t;

endpackage

`default_nettype wire

// File: hdl/rgb_status_led_patterner.sv
// top level of the rgb status led patterner
// depends on rsl_pkg and rsl_phase
//
//  channel   dir  beat contents
//  s_axis    in   tuser: command; tdata: device_status, identify_duration_ms
//  m_axis    out  tdata: red_on, green_on, blue_on, identify_active
//  cfg       in   write of led_mode, one cycle
//
// one beat per cycle sustained while m_axis_tready is high; input register,
// then one pass of logic into the output register. m_axis_tready low holds
// the output register; the input register takes one more beat, then
// s_axis_tready drops until the output drains. synchronous reset clears the
// valid flags and the block state; beat and result data are not reset.
`default_nettype none

module rgb_status_led_patterner (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [1:0]  s_axis_tuser,  // [1:0] command
  input  wire logic [39:0] s_axis_tdata,  // [2:0] device_status, [34:3] identify_duration_ms
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [7:0]  m_axis_tdata,  // [0] red_on, [1] green_on, [2] blue_on,
                                          // [3] identify_active
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_wdata
);

  // input register
  logic                 s1_valid;
  logic [1:0]           s1_cmd;
  logic [2:0]           s1_status;
  logic [31:0]          s1_dur;

  // block state
  rsl_pkg::mode_t       led_mode;
  rsl_pkg::time_t       ms_counter;
  rsl_pkg::time_t       last_update_ms;
  rsl_pkg::time_t       flash_deadline;
  rsl_pkg::time_t       identify_deadline;
  logic [2:0]           led_levels;

  rsl_pkg::time_t       ms_counter_next;
  rsl_pkg::time_t       last_update_ms_next;
  rsl_pkg::time_t       flash_deadline_next;
  rsl_pkg::time_t       identify_deadline_next;
  logic [2:0]           led_levels_next;

  logic                 out_valid;
  logic [3:0]           out_bits;

  logic                 advance;
  logic                 tick;
  logic                 hb;
  rsl_pkg::time_t       cnt_inc;
  rsl_pkg::phase_t      phase_next;
  logic [2:0]           ident_color;
  logic [2:0]           status_color;
  logic                 ident_active;

  assign advance       = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || !out_valid || m_axis_tready;
  assign tick          = (s1_cmd == rsl_pkg::CMD_TICK);
  assign cnt_inc       = ms_counter + rsl_pkg::time_t'(1);
  assign hb            = (led_mode == rsl_pkg::MODE_HEARTBEAT);

  rsl_phase u_phase (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance && tick),
    .wrap       (cnt_inc == '0),
    .phase_next (phase_next)
  );

  // red, green, blue, 100 ms each
  always_comb begin
    if (phase_next.p300 < rsl_pkg::IDENT_STEP) begin
      ident_color = rsl_pkg::LVL_R;
    end else if (phase_next.p300 < rsl_pkg::IDENT_STEP2) begin
      ident_color = rsl_pkg::LVL_G;
    end else begin
      ident_color = rsl_pkg::LVL_B;
    end
  end

  always_comb begin
    case (s1_status)
      rsl_pkg::ST_NO_NET: begin
        status_color = (!hb || phase_next.p1000 < rsl_pkg::DUTY_1000) ?
                       rsl_pkg::LVL_B : 3'b000;
      end
      rsl_pkg::ST_UNCONF: begin
        status_color = (!hb || phase_next.p2000 < rsl_pkg::DUTY_2000) ?
                       (rsl_pkg::LVL_R | rsl_pkg::LVL_G) : 3'b000;
      end
      rsl_pkg::ST_ENROLL: begin
        status_color = (phase_next.p400 < rsl_pkg::DUTY_400) ?
                       (rsl_pkg::LVL_G | rsl_pkg::LVL_B) : 3'b000;
      end
      rsl_pkg::ST_RUNNING: begin
        status_color = (!hb || phase_next.p5000 < rsl_pkg::DUTY_5000) ?
                       rsl_pkg::LVL_G : 3'b000;
      end
      rsl_pkg::ST_ERROR: begin
        status_color = (phase_next.p300 < rsl_pkg::DUTY_300) ?
                       rsl_pkg::LVL_R : 3'b000;
      end
      // unknown status keeps the current levels
      default: begin
        status_color = led_levels;
      end
    endcase
  end

  always_comb begin
    logic settled;
    settled                = 1'b0;
    ms_counter_next        = ms_counter;
    last_update_ms_next    = last_update_ms;
    flash_deadline_next    = flash_deadline;
    identify_deadline_next = identify_deadline;
    led_levels_next        = led_levels;
    case (s1_cmd)
      rsl_pkg::CMD_TICK: begin
        ms_counter_next = cnt_inc;
        if ((cnt_inc - last_update_ms) >= rsl_pkg::UPDATE_MS) begin
          last_update_ms_next = cnt_inc;
          if (identify_deadline != '0) begin
            if (cnt_inc < identify_deadline) begin
              led_levels_next = ident_color;
              settled         = 1'b1;
            end else begin
              identify_deadline_next = '0;
            end
          end
          if (!settled && led_mode == rsl_pkg::MODE_OFF) begin
            led_levels_next = 3'b000;
            settled         = 1'b1;
          end
          if (!settled && led_mode == rsl_pkg::MODE_FULL && flash_deadline != '0) begin
            if (cnt_inc < flash_deadline) begin
              led_levels_next = rsl_pkg::LVL_R | rsl_pkg::LVL_G | rsl_pkg::LVL_B;
              settled         = 1'b1;
            end else begin
              flash_deadline_next = '0;
            end
          end
          if (!settled) begin
            led_levels_next = status_color;
          end
        end
      end
      rsl_pkg::CMD_TUNNEL: begin
        if (led_mode == rsl_pkg::MODE_FULL) begin
          flash_deadline_next = ms_counter + rsl_pkg::FLASH_MS;
        end
      end
      rsl_pkg::CMD_IDENTIFY: begin
        identify_deadline_next = ms_counter + rsl_pkg::time_t'(s1_dur);
      end
      default: begin
      end
    endcase
  end

  assign ident_active = (identify_deadline_next != '0) &&
                        (ms_counter_next < identify_deadline_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      s1_cmd    <= s_axis_tuser;
      s1_status <= s_axis_tdata[2:0];
      s1_dur    <= s_axis_tdata[34:3];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_bits <= {ident_active, led_levels_next};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      led_mode          <= rsl_pkg::MODE_OFF;
      ms_counter        <= '0;
      last_update_ms    <= '0;
      flash_deadline    <= '0;
      identify_deadline <= '0;
      led_levels        <= 3'b000;
    end else begin
      if (advance) begin
        ms_counter        <= ms_counter_next;
        last_update_ms    <= last_update_ms_next;
        flash_deadline    <= flash_deadline_next;
        identify_deadline <= identify_deadline_next;
      end
      if (cfg_we) begin
        led_mode <= rsl_pkg::mode_t'(cfg_wdata);
      end
      // mode off darkens the led at once
      if (cfg_we && rsl_pkg::mode_t'(cfg_wdata) == rsl_pkg::MODE_OFF) begin
        led_levels <= 3'b000;
      end else if (advance) begin
        led_levels <= led_levels_next;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0000, out_bits};

endmodule

`default_nettype wire

// File: hdl/rsl_phase.sv
// counter residues for the blink and identify periods, kept incrementally
// depends on rsl_pkg
`default_nettype none

module rsl_phase (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           advance,
  input  wire logic           wrap,
  output rsl_pkg::phase_t     phase_next
);

  rsl_pkg::phase_t phase_q;

  // residue after one more tick; a counter wrap restarts every residue
  always_comb begin
    phase_next.p300  = (wrap || phase_q.p300 == rsl_pkg::PER_300 - 9'd1) ?
                       9'd0 : phase_q.p300 + 9'd1;
    phase_next.p1000 = (wrap || phase_q.p1000 == rsl_pkg::PER_1000 - 10'd1) ?
                       10'd0 : phase_q.p1000 + 10'd1;
    phase_next.p2000 = (wrap || phase_q.p2000 == rsl_pkg::PER_2000 - 11'd1) ?
                       11'd0 : phase_q.p2000 + 11'd1;
    phase_next.p400  = (wrap || phase_q.p400 == rsl_pkg::PER_400 - 9'd1) ?
                       9'd0 : phase_q.p400 + 9'd1;
    phase_next.p5000 = (wrap || phase_q.p5000 == rsl_pkg::PER_5000 - 13'd1) ?
                       13'd0 : phase_q.p5000 + 13'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_q <= '0;
    end else if (advance) begin
      phase_q <= phase_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/rsl_checker.sv
// port-level checks for the rgb status led patterner, bound to the top level
// depends on rgb_status_led_patterner_defines.svh
`default_nettype none

`include "rgb_status_led_patterner_defines.svh"

module rsl_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [1:0]  s_axis_tuser,
  input wire logic [39:0] s_axis_tdata,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [7:0]  m_axis_tdata,
  input wire logic        cfg_we,
  input wire logic [1:0]  cfg_wdata
);

  // a stalled result beat keeps its value
  `RSL_ASSERT_NXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // padding bits of the result stay zero
  `RSL_ASSERT_IMP(a_pad, clk, rst, m_axis_tvalid, m_axis_tdata[7:4] == 4'b0000)

  // a taken beat reaches the output in the cycle after the sink is ready
  `RSL_ASSERT_NXT(a_latency, clk, rst, (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready, m_axis_tvalid)

endmodule

bind rgb_status_led_patterner rsl_checker u_rsl_checker (.*);

`default_nettype wire

// File: dv/rgb_status_led_patterner_tb.sv
// self-checking testbench for rgb_status_led_patterner: directed and random command beats,
// with the led levels predicted per accepted beat and checked in order on m_axis
// depends on rsl_pkg and the rgb_status_led_patterner rtl
`timescale 1ns / 1ps

module rgb_status_led_patterner_tb;
  import rsl_pkg::*;

  localparam logic [1:0] CMD_RESERVED = 2'd3;
  localparam int unsigned ST_RSVD_LO = 5;
  localparam int unsigned ST_RSVD_HI = 7;
  localparam int ITEMS_PER_PHASE = 205;
  localparam mode_t PHASE_MODE [6] = '{MODE_HEARTBEAT, MODE_FULL, MODE_STATUS,
                                       MODE_OFF, MODE_FULL, MODE_HEARTBEAT};

  class led_scoreboard;
    mode_t mode;
    time_t ms_now, last_eval, flash_dl, ident_dl;
    logic [2:0] lvl;
    logic [3:0] expected_leds[$];
    int errors;

    function new();
      mode = MODE_OFF;
      ms_now = '0;
      last_eval = '0;
      flash_dl = '0;
      ident_dl = '0;
      lvl = 3'b000;
      errors = 0;
    endfunction

    function void set_mode(mode_t m);
      mode = m;
      if (m == MODE_OFF) lvl = 3'b000;
    endfunction

    function logic [2:0] blink(logic [2:0] colour, int unsigned period, int unsigned duty);
      return (ms_now % period < duty) ? colour : 3'b000;
    endfunction

    function void reevaluate(logic [2:0] st);
      bit hb;
      int unsigned ph;
      hb = (mode == MODE_HEARTBEAT);
      // throttle: at most one update per 50 ms
      if (time_t'(ms_now - last_eval) < UPDATE_MS) return;
      last_eval = ms_now;
      if (ident_dl != '0) begin
        if (ms_now < ident_dl) begin
          ph = (ms_now / 100) % 3;
          lvl = (ph == 0) ? LVL_R : (ph == 1) ? LVL_G : LVL_B;
          return;
        end
        ident_dl = '0;
      end
      if (mode == MODE_OFF) begin
        lvl = 3'b000;
        return;
      end
      // stale flash deadline is only cleared when looked at in full mode
      if (mode == MODE_FULL && flash_dl != '0) begin
        if (ms_now < flash_dl) begin
          lvl = LVL_R | LVL_G | LVL_B;
          return;
        end
        flash_dl = '0;
      end
      case (st)
        ST_NO_NET:  lvl = hb ? blink(LVL_B, 1000, 500) : LVL_B;
        ST_UNCONF:  lvl = hb ? blink(LVL_R | LVL_G, 2000, 1000) : (LVL_R | LVL_G);
        ST_ENROLL:  lvl = blink(LVL_G | LVL_B, 400, 200);
        ST_RUNNING: lvl = hb ? blink(LVL_G, 5000, 120) : LVL_G;
        ST_ERROR:   lvl = blink(LVL_R, 300, 150);
        default: ;  // unknown status holds the levels
      endcase
    endfunction

    function void note_beat(logic [1:0] cmd, logic [2:0] st, time_t dur);
      bit ident_on;
      case (cmd)
        CMD_TICK: begin
          ms_now = ms_now + 1'b1;
          reevaluate(st);
        end
        CMD_TUNNEL: if (mode == MODE_FULL) flash_dl = ms_now + FLASH_MS;
        CMD_IDENTIFY: ident_dl = ms_now + dur;
        default: ;
      endcase
      ident_on = (ident_dl != '0) && (ms_now < ident_dl);
      expected_leds.push_back({ident_on, lvl});
    endfunction

    function void check_result(logic [7:0] data);
      logic [3:0] exp_leds;
      string fname [4];
      fname = '{"red_on", "green_on", "blue_on", "identify_active"};
      if (expected_leds.size() == 0) begin
        $display("%0t: result %h arrived with nothing expected", $time, data);
        errors++;
        return;
      end
      exp_leds = expected_leds.pop_front();
      for (int i = 0; i < 4; i++) begin
        if (data[i] !== exp_leds[i]) begin
          $display("%0t: %s expected %0b actual %0b", $time, fname[i], exp_leds[i], data[i]);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_leds.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [1:0] s_axis_tuser = 2'b00;   // [1:0] command
  logic [39:0] s_axis_tdata = '0;     // [2:0] device_status, [34:3] identify_duration_ms
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [0] red_on, [1] green_on, [2] blue_on,
                                      // [3] identify_active
  logic cfg_we = 1'b0;
  logic [1:0] cfg_wdata = 2'b00;

  led_scoreboard sb = new();
  int src_idle = 0;
  int sink_idle = 0;

  rgb_status_led_patterner dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tuser(s_axis_tuser),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: check each accepted beat, then pick the next ready level
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    m_axis_tready <= ($urandom_range(99) >= sink_idle);
  end

  task automatic send_beat(logic [1:0] cmd, logic [2:0] st, time_t dur);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {5'b00000, dur, st};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_beat(cmd, st, dur);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(mode_t m);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    sb.set_mode(m);
    cfg_we <= 1'b0;
  endtask

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    logic [2:0] cur_status;
    logic [1:0] cmd;
    logic [2:0] st;
    time_t dur;
    int r;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_mode(MODE_HEARTBEAT);

    // directed: every status, ignored commands, identify edge durations
    for (int s = 0; s < 8; s++) send_beat(CMD_TICK, s[2:0], $urandom());
    send_beat(CMD_TUNNEL, 3'd7, 32'hFFFF_FFFF);
    send_beat(CMD_RESERVED, 3'd7, 32'hFFFF_FFFF);
    send_beat(CMD_RESERVED, 3'd0, 32'h0000_0000);
    send_beat(CMD_IDENTIFY, ST_ERROR, 32'hFFFF_FFFF);
    send_beat(CMD_TICK, ST_RUNNING, 32'h0);
    // deadline that wraps to exactly zero stays inactive
    send_beat(CMD_IDENTIFY, ST_NO_NET, 32'd0 - sb.ms_now);
    send_beat(CMD_TICK, ST_RUNNING, 32'hFFFF_FFFF);
    // deadline near the top of the counter range, short of a wrap
    send_beat(CMD_IDENTIFY, ST_NO_NET, 32'hFFFF_FFF0);
    send_beat(CMD_TICK, ST_RUNNING, 32'h5555_5555);
    send_beat(CMD_IDENTIFY, ST_UNCONF, 32'h0);
    send_beat(CMD_TICK, ST_RUNNING, 32'hAAAA_AAAA);

    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        wait_drained();
        write_mode(PHASE_MODE[ph]);
      end
      src_idle = (ph < 2) ? 32 : (ph < 4) ? 54 : 0;
      sink_idle = (ph < 2) ? 54 : (ph < 4) ? 32 : 0;
      // start on running so the short heartbeat pulse is seen early on
      cur_status = (ph == 0) ? ST_RUNNING : 3'($urandom_range(4));
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 2 && n == 100) wait_drained();
        r = $urandom_range(99);
        st = 3'($urandom_range(7));
        dur = $urandom();
        if (r < 90) begin
          cmd = CMD_TICK;
          if ($urandom_range(99) < 3)
            cur_status = ($urandom_range(99) < 15) ? 3'($urandom_range(ST_RSVD_HI, ST_RSVD_LO))
                                                  : 3'($urandom_range(4));
          st = cur_status;
        end else if (r < 95) begin
          cmd = CMD_TUNNEL;
        end else if (r < 97) begin
          cmd = CMD_IDENTIFY;
          r = $urandom_range(99);
          if (r < 60) dur = $urandom_range(700, 100);
          else if (r < 80) dur = 32'd0 - sb.ms_now;
          else if (r < 90) dur = 32'h0;
        end else begin
          cmd = CMD_RESERVED;
        end
        send_beat(cmd, st, dur);
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
